### hw/rtl/xor_checksum_double_hash_placer_core_assert.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef XOR_CHECKSUM_DOUBLE_HASH_PLACER_CORE_ASSERT_SVH
`define XOR_CHECKSUM_DOUBLE_HASH_PLACER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCDH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCDH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/xcdh_pkg.sv
`default_nettype none
package xcdh_pkg;

	localparam int DEF_MAX_SERVERS = 64;
	localparam int DEF_FILL_WIDTH  = 10;

	// Field and register widths.
	localparam int KEY_W      = 8;
	localparam int SRV_W      = 6;
	localparam int FILL_OUT_W = 10;
	localparam int CNT_W      = 7;
	localparam int CAP_W      = 10;
	localparam int CFG_W      = 10;
	localparam int CFG_IDX_W  = 1;

	// Hash constants.
	localparam int unsigned H1_MUL     = 7919;
	localparam int unsigned H2_MUL     = 104729;
	localparam int unsigned H2_ADD     = 123;
	localparam logic [KEY_W-1:0] SPACE_BYTE = 8'h20;

	// Both hash products fit in 25 bits; the remainder unit walks them bit by bit.
	localparam int DIV_W     = 25;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SERVER_COUNT    = 1'b0,
		REG_SERVER_CAPACITY = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic clr_wr;
		logic take;
		logic div_step;
		logic probe_init;
		logic probe_next;
		logic latch_hit;
		logic latch_drop;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic room;
		logic probe_last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/xcdh_if.sv
`default_nettype none
interface xcdh_key_if;
	logic                       valid;
	logic                       ready;
	logic [xcdh_pkg::KEY_W-1:0] key_byte;
	logic                       last_byte;

	modport source (output valid, output key_byte, output last_byte, input ready);
	modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface xcdh_res_if;
	logic                            valid;
	logic                            ready;
	logic [xcdh_pkg::SRV_W-1:0]      chosen_server;
	logic [xcdh_pkg::SRV_W-1:0]      home_server;
	logic                            moved;
	logic                            placed;
	logic [xcdh_pkg::FILL_OUT_W-1:0] new_fill;

	modport source (output valid, output chosen_server, output home_server, output moved,
		output placed, output new_fill, input ready);
	modport sink (input valid, input chosen_server, input home_server, input moved,
		input placed, input new_fill, output ready);
endinterface
`default_nettype wire

### hw/rtl/xcdh_ram.sv
`default_nettype none
module xcdh_ram #(
	parameter int WIDTH  = 10,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/xcdh_dp.sv
`default_nettype none
module xcdh_dp #(
	parameter int MAX_SERVERS = xcdh_pkg::DEF_MAX_SERVERS,
	parameter int FILL_WIDTH  = xcdh_pkg::DEF_FILL_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [xcdh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xcdh_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [xcdh_pkg::KEY_W-1:0]      key_byte,
	input  logic                            last_byte,
	input  xcdh_pkg::ctrl_cmd_t             cmd,
	output xcdh_pkg::dp_status_t            status,
	input  logic                            res_ready,
	output logic                            res_valid,
	output logic [xcdh_pkg::SRV_W-1:0]      chosen_server,
	output logic [xcdh_pkg::SRV_W-1:0]      home_server,
	output logic                            moved,
	output logic                            placed,
	output logic [xcdh_pkg::FILL_OUT_W-1:0] new_fill
);
	import xcdh_pkg::*;

	localparam int SIDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CMP_W  = (FILL_WIDTH > CAP_W) ? FILL_WIDTH : CAP_W;
	localparam logic [FILL_WIDTH-1:0] FILL_MAX = {FILL_WIDTH{1'b1}};
	localparam logic [SIDX_W-1:0]     LAST_IDX = SIDX_W'(MAX_SERVERS - 1);

	function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] r, input logic b,
		input logic [CNT_W-1:0] n);
		logic [CNT_W:0] t;
		t = {r, b};
		if (t >= {1'b0, n}) begin
			t = t - {1'b0, n};
		end
		return t[CNT_W-1:0];
	endfunction

	logic [CNT_W-1:0]      server_count_q;
	logic [CAP_W-1:0]      server_capacity_q;
	logic [KEY_W-1:0]      xor_q;
	logic                  first_q;
	logic [SIDX_W-1:0]     clr_cnt_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  out_valid_q;

	logic [DIV_W-1:0]      div1_q;
	logic [DIV_W-1:0]      div2_q;
	logic [CNT_W-1:0]      rem1_q;
	logic [CNT_W-1:0]      rem2_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      pos_q;
	logic [CNT_W-1:0]      home_q;
	logic [CNT_W-1:0]      step_q;
	logic [CNT_W-1:0]      probe_i_q;
	logic [CNT_W-1:0]      res_chosen_q;
	logic                  res_moved_q;
	logic                  res_placed_q;
	logic [FILL_WIDTH-1:0] res_fill_q;
	logic [SRV_W-1:0]      out_chosen_q;
	logic [SRV_W-1:0]      out_home_q;
	logic                  out_moved_q;
	logic                  out_placed_q;
	logic [FILL_OUT_W-1:0] out_fill_q;

	logic [CNT_W-1:0]      n_in_use;
	logic [KEY_W-1:0]      xor_next;
	logic [DIV_W-1:0]      h1_prod;
	logic [DIV_W-1:0]      h2_prod;
	logic [CNT_W:0]        pos_sum;
	logic [CNT_W-1:0]      pos_step;
	logic [FILL_WIDTH-1:0] rd_fill;
	logic                  ram_we;
	logic [SIDX_W-1:0]     ram_waddr;
	logic [FILL_WIDTH-1:0] ram_wdata;

	always_comb begin
		if (server_count_q == '0) begin
			n_in_use = CNT_W'(1);
		end else if (int'(server_count_q) > MAX_SERVERS) begin
			n_in_use = CNT_W'(MAX_SERVERS);
		end else begin
			n_in_use = server_count_q;
		end
	end

	always_comb begin
		if (first_q) begin
			xor_next = key_byte;
		end else if (key_byte != SPACE_BYTE) begin
			xor_next = xor_q ^ key_byte;
		end else begin
			xor_next = xor_q;
		end
	end

	assign h1_prod = DIV_W'(H1_MUL) * DIV_W'(xor_next);
	assign h2_prod = DIV_W'(H2_MUL) * DIV_W'(xor_next) + DIV_W'(H2_ADD);

	// Both positions stay below n, so one conditional subtract keeps the sum reduced.
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, step_q};
		if (pos_sum >= {1'b0, n_q}) begin
			pos_sum = pos_sum - {1'b0, n_q};
		end
		pos_step = pos_sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q    <= CNT_W'(1);
			server_capacity_q <= CAP_W'(4);
			xor_q             <= '0;
			first_q           <= 1'b1;
			clr_cnt_q         <= '0;
			div_cnt_q         <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_SERVER_COUNT: begin
						server_count_q <= cfg_wdata[CNT_W-1:0];
					end
					REG_SERVER_CAPACITY: begin
						server_capacity_q <= cfg_wdata[CAP_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.take) begin
				if (last_byte) begin
					xor_q   <= '0;
					first_q <= 1'b1;
				end else begin
					xor_q   <= xor_next;
					first_q <= 1'b0;
				end
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && last_byte) begin
			div1_q <= h1_prod;
			div2_q <= h2_prod;
			rem1_q <= '0;
			rem2_q <= '0;
			n_q    <= n_in_use;
		end else if (cmd.div_step) begin
			div1_q <= div1_q << 1;
			div2_q <= div2_q << 1;
			rem1_q <= rem_step(rem1_q, div1_q[DIV_W-1], n_q);
			rem2_q <= rem_step(rem2_q, div2_q[DIV_W-1], n_q);
		end
		if (cmd.probe_init) begin
			pos_q     <= rem1_q;
			home_q    <= rem1_q;
			step_q    <= rem2_q;
			probe_i_q <= '0;
		end else if (cmd.probe_next) begin
			pos_q     <= pos_step;
			probe_i_q <= probe_i_q + 1'b1;
		end
		if (cmd.latch_hit) begin
			res_chosen_q <= pos_q;
			res_moved_q  <= (probe_i_q != '0);
			res_placed_q <= 1'b1;
			res_fill_q   <= rd_fill + 1'b1;
		end else if (cmd.latch_drop) begin
			res_chosen_q <= '0;
			res_moved_q  <= 1'b0;
			res_placed_q <= 1'b0;
			res_fill_q   <= '0;
		end
		if (cmd.commit) begin
			out_chosen_q <= SRV_W'(res_chosen_q);
			out_home_q   <= SRV_W'(home_q);
			out_moved_q  <= res_moved_q;
			out_placed_q <= res_placed_q;
			out_fill_q   <= FILL_OUT_W'(res_fill_q);
		end
	end

	// The clearing pass after reset and the placement write share the write port.
	assign ram_we    = cmd.clr_wr || (cmd.commit && res_placed_q);
	assign ram_waddr = cmd.clr_wr ? clr_cnt_q : SIDX_W'(res_chosen_q);
	assign ram_wdata = cmd.clr_wr ? '0 : res_fill_q;

	xcdh_ram #(
		.WIDTH (FILL_WIDTH),
		.DEPTH (MAX_SERVERS)
	) u_fill_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (SIDX_W'(pos_q)),
		.rdata (rd_fill)
	);

	assign status.clr_last   = (clr_cnt_q == LAST_IDX);
	assign status.div_last   = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));
	assign status.room       = (CMP_W'(rd_fill) < CMP_W'(server_capacity_q)) &&
		(rd_fill != FILL_MAX);
	assign status.probe_last = (probe_i_q == (n_q - CNT_W'(1)));
	assign status.out_free   = !out_valid_q || res_ready;

	assign res_valid     = out_valid_q;
	assign chosen_server = out_chosen_q;
	assign home_server   = out_home_q;
	assign moved         = out_moved_q;
	assign placed        = out_placed_q;
	assign new_fill      = out_fill_q;

endmodule
`default_nettype wire

### hw/rtl/xcdh_ctrl.sv
`default_nettype none
module xcdh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_valid,
	input  logic                 key_last,
	output logic                 key_ready,
	output xcdh_pkg::ctrl_cmd_t  cmd,
	input  xcdh_pkg::dp_status_t status
);
	import xcdh_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_HOME  = 7'b0001000,
		S_READ  = 7'b0010000,
		S_CHECK = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		key_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				key_ready = 1'b1;
				if (key_valid) begin
					cmd.take = 1'b1;
					if (key_last) begin
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_HOME;
				end
			end
			S_HOME: begin
				cmd.probe_init = 1'b1;
				state_d        = S_READ;
			end
			S_READ: begin
				// The fill-memory read is registered, so the fill count of the current position is ready in S_CHECK.
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (status.room) begin
					cmd.latch_hit = 1'b1;
					state_d       = S_DONE;
				end else if (status.probe_last) begin
					cmd.latch_drop = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_READ;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/xor_checksum_double_hash_placer_core.sv
`default_nettype none
// Key placer: key bytes arrive one per request on the key channel, and each key's last byte
// yields one result on the result channel. A byte that is not the last of its key is taken
// while the controller stays idle, so keys stream at one byte per cycle. The last byte starts
// the end of key work: the bit-serial remainder unit reduces both hash products modulo the
// server count, the probe is set up, then each probed server gets a fill-memory read and its
// check (home server first, at most n servers), and a commit, once the output register is
// free, writes the fill count and loads the result register. No bytes are taken during
// that work, but a finished result may wait in its output register while the next key
// streams in. After reset all MAX_SERVERS fill-memory entries are cleared, one entry per
// cycle, before the first byte is taken; configuration writes are taken at any time.
module xor_checksum_double_hash_placer_core #(
	parameter int MAX_SERVERS = xcdh_pkg::DEF_MAX_SERVERS,
	parameter int FILL_WIDTH  = xcdh_pkg::DEF_FILL_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [xcdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xcdh_pkg::CFG_W-1:0]     cfg_wdata,
	xcdh_key_if.sink                       key,
	xcdh_res_if.source                     result
);
	import xcdh_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	xcdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key.valid),
		.key_last  (key.last_byte),
		.key_ready (key.ready),
		.cmd       (cmd),
		.status    (status)
	);

	xcdh_dp #(
		.MAX_SERVERS (MAX_SERVERS),
		.FILL_WIDTH  (FILL_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.key_byte      (key.key_byte),
		.last_byte     (key.last_byte),
		.cmd           (cmd),
		.status        (status),
		.res_ready     (result.ready),
		.res_valid     (result.valid),
		.chosen_server (result.chosen_server),
		.home_server   (result.home_server),
		.moved         (result.moved),
		.placed        (result.placed),
		.new_fill      (result.new_fill)
	);

endmodule
`default_nettype wire

### hw/rtl/xcdh_checker.sv
`default_nettype none
`include "xor_checksum_double_hash_placer_core_assert.svh"
module xcdh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [xcdh_pkg::SRV_W-1:0]      chosen_server,
	input logic [xcdh_pkg::SRV_W-1:0]      home_server,
	input logic                            moved,
	input logic                            placed,
	input logic [xcdh_pkg::FILL_OUT_W-1:0] new_fill
);

	// A result request that is not taken stays up with the same payload.
	`XCDH_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid, "result request dropped")
	`XCDH_ASSERT_NEXT(a_res_stable, out_valid && !out_ready, $stable(chosen_server) && $stable(home_server) && $stable(moved) && $stable(placed) && $stable(new_fill), "result payload changed while stalled")

	// A dropped key reports zeros in every field except the home position.
	`XCDH_ASSERT_SAME(a_drop_zero, out_valid && !placed, chosen_server == '0 && !moved && new_fill == '0, "dropped key with nonzero fields")
	`XCDH_ASSERT_SAME(a_moved_placed, out_valid && moved, placed, "moved key not marked placed")
	`XCDH_ASSERT_SAME(a_home_hit, out_valid && placed && !moved, chosen_server == home_server, "unmoved key not at home server")

endmodule

bind xor_checksum_double_hash_placer_core xcdh_checker u_xcdh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.chosen_server (result.chosen_server),
	.home_server   (result.home_server),
	.moved         (result.moved),
	.placed        (result.placed),
	.new_fill      (result.new_fill)
);
`default_nettype wire
